FILE: hw/rtl/lprt_pkg.sv
// ============================================================================
// lprt_pkg: shared codes and control types for the longest-prefix route table
// Operation and status codes, plus the command/status bundles that join the
// controller and the datapath.
// ============================================================================
package lprt_pkg;

   localparam int MODE_BITS   = 2;
   localparam int STATUS_BITS = 2;

   // operation codes
   localparam logic [MODE_BITS-1:0] MODE_LOOKUP = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_INSERT = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_DELETE = 2'd2;

   // result status codes
   localparam logic [STATUS_BITS-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL   = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_ABSENT = 2'd2;

   // controller -> datapath
   typedef struct packed {
      logic start;   // latch a request, launch the table scan
      logic clear;   // write one empty entry of the init sweep
      logic commit;  // write back and load the response register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clear_last;  // init sweep at last entry
      logic scan_last;   // last entry is being evaluated
      logic rsp_free;    // response register can take a result
   } stat_type;

endpackage

FILE: hw/rtl/lprt_req_if.sv
// ============================================================================
// lprt_req_if: request channel of the route table
// Valid/ready handshake carrying one table operation per transaction.
// ============================================================================
interface lprt_req_if #(
   parameter int ADDRESS_BITS = 16,
   parameter int LEN_BITS     = 5,
   parameter int HOP_BITS     = 8
);
   logic                           valid;
   logic                           ready;
   logic [lprt_pkg::MODE_BITS-1:0] mode;
   logic [ADDRESS_BITS-1:0]        address;
   logic [LEN_BITS-1:0]            prefix_length;
   logic [HOP_BITS-1:0]            next_hop;

   modport source (output valid, output mode, output address, output prefix_length,
                   output next_hop, input ready);
   modport sink   (input valid, input mode, input address, input prefix_length,
                   input next_hop, output ready);
endinterface

FILE: hw/rtl/lprt_rsp_if.sv
// ============================================================================
// lprt_rsp_if: response channel of the route table
// Valid/ready handshake carrying one result per transaction.
// ============================================================================
interface lprt_rsp_if #(
   parameter int HOP_BITS = 8
);
   logic                             valid;
   logic                             ready;
   logic                             hit;
   logic [HOP_BITS-1:0]              hop_out;
   logic [lprt_pkg::STATUS_BITS-1:0] status;

   modport source (output valid, output hit, output hop_out, output status, input ready);
   modport sink   (input valid, input hit, input hop_out, input status, output ready);
endinterface

FILE: hw/rtl/lprt_ctrl.sv
// ============================================================================
// lprt_ctrl: route table controller
// Sequences the init sweep, request accept, table scan and write-back.
// ============================================================================
module lprt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  lprt_pkg::stat_type stat,
   output lprt_pkg::cmd_type  cmd
);
   import lprt_pkg::*;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_COMMIT
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;

   always_comb begin
      state_in   = state_ff;
      ready_in   = ready_ff;
      cmd        = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_last) begin
               state_in = S_IDLE;
               ready_in = 1'b1;
            end
         end
         S_IDLE: begin
            cmd.start = req_valid && ready_ff;
            if (req_valid && ready_ff) begin
               state_in = S_SCAN;
               ready_in = 1'b0;
            end
         end
         S_SCAN: begin
            if (stat.scan_last) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            cmd.commit = stat.rsp_free;
            if (stat.rsp_free) begin
               state_in = S_IDLE;
               ready_in = 1'b1;
            end
         end
         default: begin
            state_in = S_CLEAR;
            ready_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_ready = ready_ff;

endmodule

FILE: hw/rtl/lprt_datapath.sv
// ============================================================================
// lprt_datapath: route table storage, scan and response register
// Entry memory with one registered read per cycle, match tracking and the
// write-back/response logic.
// ============================================================================
module lprt_datapath #(
   parameter int ENTRIES      = 64,
   parameter int ADDRESS_BITS = 16,
   parameter int HOP_BITS     = 8,
   parameter int LEN_BITS     = 5
) (
   input  logic                             clock,
   input  logic                             reset,
   input  lprt_pkg::cmd_type                cmd,
   output lprt_pkg::stat_type               stat,
   input  logic [lprt_pkg::MODE_BITS-1:0]   req_mode,
   input  logic [ADDRESS_BITS-1:0]          req_address,
   input  logic [LEN_BITS-1:0]              req_prefix_length,
   input  logic [HOP_BITS-1:0]              req_next_hop,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_hit,
   output logic [HOP_BITS-1:0]              rsp_hop_out,
   output logic [lprt_pkg::STATUS_BITS-1:0] rsp_status
);
   import lprt_pkg::*;

   localparam int IDX_BITS = $clog2(ENTRIES);
   localparam int WORD_BITS = 1 + ADDRESS_BITS + LEN_BITS + HOP_BITS;
   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(ENTRIES - 1);
   localparam logic [LEN_BITS-1:0] MAX_LEN = LEN_BITS'(ADDRESS_BITS);

   // keeps the top len bits of an address
   function automatic logic [ADDRESS_BITS-1:0] top_mask(input logic [LEN_BITS-1:0] len);
      top_mask = ~({ADDRESS_BITS{1'b1}} >> len);
   endfunction

   // entry memory: {valid, prefix, length, hop}
   logic [WORD_BITS-1:0] mem [ENTRIES];
   logic [WORD_BITS-1:0] rd_data_ff;

   // latched request
   logic [MODE_BITS-1:0]    op_mode_ff;
   logic [ADDRESS_BITS-1:0] op_addr_ff;
   logic [LEN_BITS-1:0]     op_len_ff;
   logic [HOP_BITS-1:0]     op_hop_ff;

   // scan pipeline
   logic                issue_ff;
   logic [IDX_BITS-1:0] issue_idx_ff;
   logic                eval_ff;
   logic [IDX_BITS-1:0] eval_idx_ff;
   logic [IDX_BITS-1:0] clr_idx_ff;

   // scan results
   logic [LEN_BITS-1:0] best_len_ff;
   logic [HOP_BITS-1:0] best_hop_ff;
   logic                exact_found_ff;
   logic [IDX_BITS-1:0] exact_idx_ff;
   logic                free_found_ff;
   logic [IDX_BITS-1:0] free_idx_ff;

   // response register
   logic                   rsp_valid_ff;
   logic                   rsp_hit_ff;
   logic [HOP_BITS-1:0]    rsp_hop_ff;
   logic [STATUS_BITS-1:0] rsp_status_ff;

   logic                    e_valid;
   logic [ADDRESS_BITS-1:0] e_pfx;
   logic [LEN_BITS-1:0]     e_len;
   logic [HOP_BITS-1:0]     e_hop;
   logic [ADDRESS_BITS-1:0] op_pfx;
   logic [LEN_BITS-1:0]     len_sat;
   logic                    exact_match;
   logic                    route_match;

   logic                 wr_en;
   logic [IDX_BITS-1:0]  wr_addr;
   logic [WORD_BITS-1:0] wr_data;

   assign {e_valid, e_pfx, e_len, e_hop} = rd_data_ff;
   assign op_pfx  = op_addr_ff & top_mask(op_len_ff);
   assign len_sat = (req_prefix_length > MAX_LEN) ? MAX_LEN : req_prefix_length;

   assign exact_match = e_valid && (e_len == op_len_ff) && (e_pfx == op_pfx);
   assign route_match = e_valid && (e_len != '0) && ((op_addr_ff & top_mask(e_len)) == e_pfx)
                        && (e_len > best_len_ff);

   // write port: init sweep or write-back
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = clr_idx_ff;
      wr_data = '0;
      if (cmd.clear) begin
         wr_en = 1'b1;
      end else if (cmd.commit && (op_len_ff != '0)) begin
         case (op_mode_ff)
            MODE_INSERT: begin
               wr_en   = exact_found_ff || free_found_ff;
               wr_addr = exact_found_ff ? exact_idx_ff : free_idx_ff;
               wr_data = {1'b1, op_pfx, op_len_ff, op_hop_ff};
            end
            MODE_DELETE: begin
               wr_en   = exact_found_ff;
               wr_addr = exact_idx_ff;
            end
            default: begin
               wr_en = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (issue_ff) begin
         rd_data_ff <= mem[issue_idx_ff];
      end
   end

   // request latch and scan results (payload, no reset)
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_mode_ff     <= req_mode;
         op_addr_ff     <= req_address;
         op_len_ff      <= len_sat;
         op_hop_ff      <= req_next_hop;
         best_len_ff    <= '0;
         best_hop_ff    <= '0;
         exact_found_ff <= 1'b0;
         exact_idx_ff   <= '0;
         free_found_ff  <= 1'b0;
         free_idx_ff    <= '0;
      end else if (eval_ff) begin
         if (exact_match && !exact_found_ff) begin
            exact_found_ff <= 1'b1;
            exact_idx_ff   <= eval_idx_ff;
         end
         if (!e_valid && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= eval_idx_ff;
         end
         if (route_match) begin
            best_len_ff <= e_len;
            best_hop_ff <= e_hop;
         end
      end
   end

   // scan and sweep control
   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff     <= 1'b0;
         issue_idx_ff <= '0;
         eval_ff      <= 1'b0;
         eval_idx_ff  <= '0;
         clr_idx_ff   <= '0;
      end else begin
         eval_ff     <= issue_ff;
         eval_idx_ff <= issue_idx_ff;
         if (cmd.start) begin
            issue_ff     <= 1'b1;
            issue_idx_ff <= '0;
         end else if (issue_ff) begin
            if (issue_idx_ff == LAST_IDX) begin
               issue_ff <= 1'b0;
            end else begin
               issue_idx_ff <= issue_idx_ff + 1'b1;
            end
         end
         if (cmd.clear) begin
            clr_idx_ff <= (clr_idx_ff == LAST_IDX) ? '0 : clr_idx_ff + 1'b1;
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_hit_ff    <= 1'b0;
         rsp_hop_ff    <= '0;
         rsp_status_ff <= STATUS_OK;
         case (op_mode_ff)
            MODE_LOOKUP: begin
               rsp_hit_ff <= (best_len_ff != '0);
               rsp_hop_ff <= best_hop_ff;
            end
            MODE_INSERT: begin
               if ((op_len_ff != '0) && !exact_found_ff && !free_found_ff) begin
                  rsp_status_ff <= STATUS_FULL;
               end
            end
            MODE_DELETE: begin
               if ((op_len_ff == '0) || !exact_found_ff) begin
                  rsp_status_ff <= STATUS_ABSENT;
               end
            end
            default: begin
               rsp_status_ff <= STATUS_OK;
            end
         endcase
      end
   end

   assign stat.clear_last = (clr_idx_ff == LAST_IDX);
   assign stat.scan_last  = eval_ff && (eval_idx_ff == LAST_IDX);
   assign stat.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_hit     = rsp_hit_ff;
   assign rsp_hop_out = rsp_hop_ff;
   assign rsp_status  = rsp_status_ff;

endmodule

FILE: hw/rtl/longest_prefix_route_table.sv
// ============================================================================
// longest_prefix_route_table: longest-prefix-match routing table
// Stores up to ENTRIES prefixes with next hops; supports lookup, insert and
// delete, one transaction at a time.
// ============================================================================
//
//  channel   | direction | payload
//  ----------+-----------+----------------------------------------------
//  req_bus   | in        | mode, address, prefix_length, next_hop
//  rsp_bus   | out       | hit, hop_out, status
//
//  A transaction runs from accept through the scan to write-back and the
//  next accept: the entry memory has one read port, so the scan reads one
//  entry a cycle, and each read is registered before it is evaluated.
//  After reset an init sweep empties every entry of the memory, one entry a
//  cycle; req_bus.ready stays low until it ends.
//  A result parks in the response register; a new request is taken while it
//  waits, and write-back stalls only if the previous result is still there.
//
module longest_prefix_route_table #(
   parameter int ENTRIES      = 64,
   parameter int ADDRESS_BITS = 16,
   parameter int HOP_BITS     = 8
) (
   input logic    clock,
   input logic    reset,
   lprt_req_if.sink   req_bus,
   lprt_rsp_if.source rsp_bus
);
   import lprt_pkg::*;

   // prefix length field holds 0..ADDRESS_BITS
   localparam int LEN_BITS = $clog2(ADDRESS_BITS + 1);

   cmd_type  cmd;
   stat_type stat;

   // sequencing: sweep, accept, scan, write-back
   lprt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // storage, match tracking and response register
   lprt_datapath #(
      .ENTRIES      (ENTRIES),
      .ADDRESS_BITS (ADDRESS_BITS),
      .HOP_BITS     (HOP_BITS),
      .LEN_BITS     (LEN_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_mode          (req_bus.mode),
      .req_address       (req_bus.address),
      .req_prefix_length (req_bus.prefix_length),
      .req_next_hop      (req_bus.next_hop),
      .rsp_valid         (rsp_bus.valid),
      .rsp_ready         (rsp_bus.ready),
      .rsp_hit           (rsp_bus.hit),
      .rsp_hop_out       (rsp_bus.hop_out),
      .rsp_status        (rsp_bus.status)
   );

endmodule
